// ----- design/qrs_pkg.sv -----
// ============================================================================
// qrs_pkg: shared types and constants of the quadratic root solver
// Root status codes, fixed output widths and the width helper.
// ============================================================================
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int DISC_W         = 34;
    localparam int ROOT_W         = 32;
    localparam int ROOT_FRAC      = 16;
    localparam int COEF_FRAC      = 8;

    typedef enum logic [1:0] {
        ST_TWO_ROOTS  = 2'd0,
        ST_ONE_ROOT   = 2'd1,
        ST_NO_ROOTS   = 2'd2,
        ST_DEGENERATE = 2'd3
    } status_t;

    // Extra fraction bits of the square root beyond the coefficient fraction.
    function automatic int sqrt_extra(input int cw);
        int e;
        e = (62 - 2 * cw - 2) / 2;
        return (e > 8) ? 8 : e;
    endfunction

endpackage

// ----- design/qrs_if.sv -----
// ============================================================================
// qrs_coef_if / qrs_root_if: valid-ready channels of the root solver
// One transaction moves at a clock edge with valid and ready both high.
// ============================================================================
interface qrs_coef_if
    import qrs_pkg::*;
#(
    parameter int CW = COEF_WIDTH_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if
    import qrs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               root_status;
    logic signed [DISC_W-1:0] discriminant;
    logic signed [ROOT_W-1:0] root_one;
    logic signed [ROOT_W-1:0] root_two;
    logic                     overflowed;

    modport source (output valid, root_status, discriminant, root_one, root_two, overflowed,
                    input ready);
    modport sink   (input valid, root_status, discriminant, root_one, root_two, overflowed,
                    output ready);
endinterface

// ----- design/qrs_sqrt.sv -----
// ============================================================================
// qrs_sqrt: pipelined floor square root
// One root bit per stage; a side word travels along with each operand.
// ============================================================================
module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int XW  = 50,
    parameter int SBW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [XW-1:0]     in_x,
    input  logic [SBW-1:0]    in_side,
    output logic              out_vld,
    output logic [XW/2-1:0]   out_root,
    output logic [SBW-1:0]    out_side
);
    localparam int SW = XW / 2;

    logic [XW-1:0]  x_s    [SW+1];
    logic [SW-1:0]  rem_s  [SW+1];
    logic [SW-1:0]  root_s [SW+1];
    logic [SBW-1:0] side_s [SW+1];
    logic           vld_s  [SW+1];

    assign x_s[0]    = in_x;
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;
    assign side_s[0] = in_side;
    assign vld_s[0]  = in_vld;

    for (genvar i = 0; i < SW; i++) begin : g_stage
        logic [SW+1:0]  rem_sh;
        logic [SW+1:0]  trial;
        logic           take;
        logic [SW+1:0]  rem_next;
        logic [XW-1:0]  x_reg;
        logic [SW-1:0]  rem_reg;
        logic [SW-1:0]  root_reg;
        logic [SBW-1:0] side_reg;
        logic           vld_reg;

        assign rem_sh   = {rem_s[i], x_s[i][XW-1:XW-2]};
        assign trial    = {root_s[i], 2'b01};
        assign take     = (rem_sh >= trial);
        assign rem_next = take ? (rem_sh - trial) : rem_sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_s[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg    <= {x_s[i][XW-3:0], 2'b00};
                rem_reg  <= rem_next[SW-1:0];
                root_reg <= {root_s[i][SW-2:0], take};
                side_reg <= side_s[i];
            end
        end

        assign x_s[i+1]    = x_reg;
        assign rem_s[i+1]  = rem_reg;
        assign root_s[i+1] = root_reg;
        assign side_s[i+1] = side_reg;
        assign vld_s[i+1]  = vld_reg;
    end

    assign out_vld  = vld_s[SW];
    assign out_root = root_s[SW];
    assign out_side = side_s[SW];

endmodule

// ----- design/qrs_div.sv -----
// ============================================================================
// qrs_div: pipelined two-lane unsigned divider
// Restoring division, one quotient bit per stage, both lanes share a divisor.
// ============================================================================
module qrs_div
    import qrs_pkg::*;
#(
    parameter int NW  = 33,
    parameter int DV  = 16,
    parameter int SBW = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  logic [NW-1:0]  in_num_one,
    input  logic [NW-1:0]  in_num_two,
    input  logic [DV-1:0]  in_den,
    input  logic [SBW-1:0] in_side,
    output logic           out_vld,
    output logic [NW-1:0]  out_quo_one,
    output logic [NW-1:0]  out_quo_two,
    output logic [SBW-1:0] out_side
);
    logic [NW-1:0]  n1_s   [NW+1];
    logic [NW-1:0]  n2_s   [NW+1];
    logic [DV-1:0]  r1_s   [NW+1];
    logic [DV-1:0]  r2_s   [NW+1];
    logic [DV-1:0]  den_s  [NW+1];
    logic [SBW-1:0] side_s [NW+1];
    logic           vld_s  [NW+1];

    assign n1_s[0]   = in_num_one;
    assign n2_s[0]   = in_num_two;
    assign r1_s[0]   = '0;
    assign r2_s[0]   = '0;
    assign den_s[0]  = in_den;
    assign side_s[0] = in_side;
    assign vld_s[0]  = in_vld;

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [DV:0]    sh1;
        logic [DV:0]    sh2;
        logic [DV:0]    dx;
        logic           ge1;
        logic           ge2;
        logic [DV:0]    rn1;
        logic [DV:0]    rn2;
        logic [NW-1:0]  n1_reg;
        logic [NW-1:0]  n2_reg;
        logic [DV-1:0]  r1_reg;
        logic [DV-1:0]  r2_reg;
        logic [DV-1:0]  den_reg;
        logic [SBW-1:0] side_reg;
        logic           vld_reg;

        assign dx  = {1'b0, den_s[i]};
        assign sh1 = {r1_s[i], n1_s[i][NW-1]};
        assign sh2 = {r2_s[i], n2_s[i][NW-1]};
        assign ge1 = (sh1 >= dx);
        assign ge2 = (sh2 >= dx);
        assign rn1 = ge1 ? (sh1 - dx) : sh1;
        assign rn2 = ge2 ? (sh2 - dx) : sh2;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_s[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n1_reg   <= {n1_s[i][NW-2:0], ge1};
                n2_reg   <= {n2_s[i][NW-2:0], ge2};
                r1_reg   <= rn1[DV-1:0];
                r2_reg   <= rn2[DV-1:0];
                den_reg  <= den_s[i];
                side_reg <= side_s[i];
            end
        end

        assign n1_s[i+1]   = n1_reg;
        assign n2_s[i+1]   = n2_reg;
        assign r1_s[i+1]   = r1_reg;
        assign r2_s[i+1]   = r2_reg;
        assign den_s[i+1]  = den_reg;
        assign side_s[i+1] = side_reg;
        assign vld_s[i+1]  = vld_reg;
    end

    assign out_vld     = vld_s[NW];
    assign out_quo_one = n1_s[NW];
    assign out_quo_two = n2_s[NW];
    assign out_side    = side_s[NW];

endmodule

// ----- design/quadratic_root_solver.sv -----
// ============================================================================
// quadratic_root_solver: real roots of a*x^2 + b*x + c = 0
// Fully pipelined discriminant, square root, divide and saturation datapath.
// ============================================================================
//
//  channel | role  | payload
//  --------+-------+-----------------------------------------------------------
//  coefs   | sink  | coef_a, coef_b, coef_c (signed, 8 fraction bits)
//  roots   | source| root_status, discriminant, root_one, root_two, overflowed
//
//  One transaction per cycle in and out while the output is not stalled. The
//  pipeline has two product/discriminant stages, one stage per square root
//  bit, a numerator stage, one stage per quotient bit, and the output
//  register. Reset clears every valid bit; payload is not reset.
//  A stalled output freezes the whole pipeline in place: nothing is dropped
//  or repeated, and coefs.ready is high whenever the output can move.
//
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    qrs_coef_if.sink   coefs,
    qrs_root_if.source roots
);
    localparam int CW    = COEF_WIDTH;
    localparam int SE    = sqrt_extra(CW);
    localparam int DW    = 2 * CW + 2;              // discriminant width
    localparam int SW    = CW + 1 + SE;             // square root width
    localparam int XW    = 2 * SW;                  // radicand width
    localparam int NUMW  = SW + 2;                  // signed numerator width
    localparam int SHL   = ROOT_FRAC - 1 - SE;
    localparam int NW    = NUMW - 1 + SHL;          // dividend width
    localparam int DXW   = (DW > DISC_W) ? DW : DISC_W;
    localparam int QXW   = (NW > ROOT_W + 1) ? NW : ROOT_W + 1;
    localparam int SQSBW = 2 * CW + DW;
    localparam int DVSBW = 2 + DISC_W + 2;

    localparam logic [QXW-1:0] POS_MAX = QXW'(64'h0000_0000_7FFF_FFFF);
    localparam logic [QXW-1:0] NEG_MAX = QXW'(64'h0000_0000_8000_0000);

    // Global advance: move every stage when the output register is free.
    logic en;
    assign en          = !roots.valid || roots.ready;
    assign coefs.ready = en;

    // Stage A: products b*b and a*c.
    logic                   va_reg;
    logic signed [CW-1:0]   a_a_reg;
    logic signed [CW-1:0]   a_b_reg;
    logic signed [2*CW-1:0] bb_reg;
    logic signed [2*CW-1:0] ac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= coefs.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_a_reg <= coefs.coef_a;
            a_b_reg <= coefs.coef_b;
            bb_reg  <= coefs.coef_b * coefs.coef_b;
            ac_reg  <= coefs.coef_a * coefs.coef_c;
        end
    end

    // Stage B: discriminant D = b*b - 4*a*c, exact in DW bits.
    logic                 vb_reg;
    logic signed [CW-1:0] b_a_reg;
    logic signed [CW-1:0] b_b_reg;
    logic signed [DW-1:0] d_reg;
    logic signed [DW-1:0] d_next;

    assign d_next = $signed({{2{bb_reg[2*CW-1]}}, bb_reg})
                  - $signed({ac_reg, 2'b00});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_a_reg <= a_a_reg;
            b_b_reg <= a_b_reg;
            d_reg   <= d_next;
        end
    end

    // Square root of D scaled by 2^(2*SE); a negative D is fed as zero.
    logic [XW-1:0]    radicand;
    logic             sq_vld;
    logic [SW-1:0]    sq_root;
    logic [SQSBW-1:0] sq_side;

    assign radicand = d_reg[DW-1] ? '0 : {1'b0, d_reg[DW-2:0], {(2 * SE){1'b0}}};

    qrs_sqrt #(
        .XW  (XW),
        .SBW (SQSBW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vb_reg),
        .in_x     (radicand),
        .in_side  ({b_a_reg, b_b_reg, d_reg}),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // Stage C: numerators -b*2^SE +/- sqrt, magnitudes, signs and status.
    logic signed [CW-1:0]   c_a;
    logic signed [CW-1:0]   c_b;
    logic signed [DW-1:0]   c_d;
    logic [CW-1:0]          b_mag;
    logic [CW-1:0]          a_mag;
    logic                   b_pos;
    logic signed [NUMW-1:0] b_sh;
    logic signed [NUMW-1:0] nb;
    logic signed [NUMW-1:0] s_ext;
    logic signed [NUMW-1:0] num_one;
    logic signed [NUMW-1:0] num_two;
    logic [NUMW-1:0]        mag_one;
    logic [NUMW-1:0]        mag_two;
    logic signed [DXW-1:0]  d_ext;
    status_t                status;

    assign {c_a, c_b, c_d} = sq_side;
    assign b_mag   = c_b[CW-1] ? CW'(-c_b) : c_b;
    assign a_mag   = c_a[CW-1] ? CW'(-c_a) : c_a;
    assign b_pos   = !c_b[CW-1] && (c_b != '0);
    assign b_sh    = $signed({{(NUMW - CW - SE){1'b0}}, b_mag, {SE{1'b0}}});
    assign nb      = b_pos ? -b_sh : b_sh;
    assign s_ext   = $signed({2'b00, sq_root});
    assign num_one = nb + s_ext;
    assign num_two = nb - s_ext;
    assign mag_one = num_one[NUMW-1] ? -num_one : num_one;
    assign mag_two = num_two[NUMW-1] ? -num_two : num_two;
    assign d_ext   = DXW'(c_d);

    always_comb
    begin
        if (c_a == '0)
        begin
            status = ST_DEGENERATE;
        end
        else if (c_d[DW-1])
        begin
            status = ST_NO_ROOTS;
        end
        else if (c_d == '0)
        begin
            status = ST_ONE_ROOT;
        end
        else
        begin
            status = ST_TWO_ROOTS;
        end
    end

    logic             vc_reg;
    logic [NW-1:0]    n1_reg;
    logic [NW-1:0]    n2_reg;
    logic [CW-1:0]    den_reg;
    logic [DVSBW-1:0] cside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg    <= {mag_one[NUMW-2:0], {SHL{1'b0}}};
            n2_reg    <= {mag_two[NUMW-2:0], {SHL{1'b0}}};
            den_reg   <= a_mag;
            cside_reg <= {status, d_ext[DISC_W-1:0],
                          num_one[NUMW-1] ^ c_a[CW-1],
                          num_two[NUMW-1] ^ c_a[CW-1]};
        end
    end

    // Quotients |num| * 2^SHL / |a|, truncated toward zero.
    logic             dv_vld;
    logic [NW-1:0]    q_one;
    logic [NW-1:0]    q_two;
    logic [DVSBW-1:0] dv_side;

    qrs_div #(
        .NW  (NW),
        .DV  (CW),
        .SBW (DVSBW)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_vld      (vc_reg),
        .in_num_one  (n1_reg),
        .in_num_two  (n2_reg),
        .in_den      (den_reg),
        .in_side     (cside_reg),
        .out_vld     (dv_vld),
        .out_quo_one (q_one),
        .out_quo_two (q_two),
        .out_side    (dv_side)
    );

    // Final stage: apply signs, saturate, and mask roots for root-less cases.
    status_t          f_status;
    logic [DISC_W-1:0] f_disc;
    logic             f_neg_one;
    logic             f_neg_two;
    logic [QXW-1:0]   qx_one;
    logic [QXW-1:0]   qx_two;
    logic [QXW-1:0]   qn_one;
    logic [QXW-1:0]   qn_two;
    logic [ROOT_W-1:0] r_one;
    logic [ROOT_W-1:0] r_two;
    logic             ovf_one;
    logic             ovf_two;
    logic             has_roots;

    assign f_status  = status_t'(dv_side[DVSBW-1 -: 2]);
    assign f_disc    = dv_side[DISC_W+1:2];
    assign f_neg_one = dv_side[1];
    assign f_neg_two = dv_side[0];
    assign qx_one    = QXW'(q_one);
    assign qx_two    = QXW'(q_two);
    assign qn_one    = -qx_one;
    assign qn_two    = -qx_two;
    assign has_roots = (f_status == ST_TWO_ROOTS) || (f_status == ST_ONE_ROOT);

    always_comb
    begin
        if (f_neg_one)
        begin
            ovf_one = (qx_one > NEG_MAX);
            r_one   = ovf_one ? NEG_MAX[ROOT_W-1:0] : qn_one[ROOT_W-1:0];
        end
        else
        begin
            ovf_one = (qx_one > POS_MAX);
            r_one   = ovf_one ? POS_MAX[ROOT_W-1:0] : qx_one[ROOT_W-1:0];
        end
        if (f_neg_two)
        begin
            ovf_two = (qx_two > NEG_MAX);
            r_two   = ovf_two ? NEG_MAX[ROOT_W-1:0] : qn_two[ROOT_W-1:0];
        end
        else
        begin
            ovf_two = (qx_two > POS_MAX);
            r_two   = ovf_two ? POS_MAX[ROOT_W-1:0] : qx_two[ROOT_W-1:0];
        end
    end

    // Output register: hold while the sink stalls.
    logic              out_vld_reg;
    logic [1:0]        status_reg;
    logic [DISC_W-1:0] disc_reg;
    logic [ROOT_W-1:0] one_reg;
    logic [ROOT_W-1:0] two_reg;
    logic              ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= f_status;
            disc_reg   <= f_disc;
            one_reg    <= has_roots ? r_one : '0;
            two_reg    <= has_roots ? r_two : '0;
            ovf_reg    <= has_roots && (ovf_one || ovf_two);
        end
    end

    assign roots.valid        = out_vld_reg;
    assign roots.root_status  = status_reg;
    assign roots.discriminant = $signed(disc_reg);
    assign roots.root_one     = $signed(one_reg);
    assign roots.root_two     = $signed(two_reg);
    assign roots.overflowed   = ovf_reg;

endmodule
